### rtl/core/esnf_pkg.sv
// ----------------------------------------------------------------------------
// esnf_pkg
// Word types and shared constants for the eventual safe node finder.
// ----------------------------------------------------------------------------
package esnf_pkg;

  localparam int unsigned NodeW  = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef struct packed {
    logic             opcode;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
  } in_word_t;

  typedef struct packed {
    logic [63:0]       safe_mask;
    logic [CountW-1:0] safe_count;
    logic              edges_dropped;
  } out_word_t;

endpackage

### rtl/core/esnf_edge_mem.sv
// ----------------------------------------------------------------------------
// esnf_edge_mem
// Edge store: one write port, one registered read port. Each entry holds a
// source and a target node.
// ----------------------------------------------------------------------------
module esnf_edge_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [2*esnf_pkg::NodeW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [2*esnf_pkg::NodeW-1:0] rdata_o
);
  import esnf_pkg::*;

  logic [2*NodeW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/esnf_stack_mem.sv
// ----------------------------------------------------------------------------
// esnf_stack_mem
// Walk stack: node and edge cursor per level, registered read.
// ----------------------------------------------------------------------------
module esnf_stack_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 15
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/eventual_safe_node_finder.sv
// ----------------------------------------------------------------------------
// eventual_safe_node_finder
// Edge loader and depth-first safe node search over a stored graph.
// ----------------------------------------------------------------------------
// Add words are taken in the idle state and can follow back to back. An
// evaluate word starts a depth-first walk. The edge scan issues the read of
// one edge memory entry in the scan state and checks it in the edge state, so
// it does not read the next entry until the last one is checked. Each visited
// node scans the stored edges at most once. Each node also passes through root
// setup, a pop and the reload of its parent from the stack. Input is stalled
// during the walk. The result sits in an output register until taken.
module eventual_safe_node_finder #(
  parameter int unsigned MaxNodes = 64,
  parameter int unsigned MaxEdges = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  esnf_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output esnf_pkg::out_word_t  out_word_o
);
  import esnf_pkg::*;

  localparam int unsigned EAddrW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned ECntW  = $clog2(MaxEdges + 1);
  localparam int unsigned SAddrW = $clog2(MaxNodes);
  localparam int unsigned SCntW  = $clog2(MaxNodes + 1);
  localparam int unsigned SDataW = NodeW + ECntW;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ROOT  = 7'b0000010,
    ST_TOPRD = 7'b0000100,
    ST_TOP   = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_EDGE  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [6:0]        ncnt_q;
  logic [ECntW-1:0]  ecnt_q, ecnt_d;
  logic              drop_q, drop_d;
  logic [63:0]       seen_q, seen_d, path_q, path_d, safe_q, safe_d;
  logic [SCntW-1:0]  sp_q, sp_d;
  logic [6:0]        root_q, root_d;
  logic [NodeW-1:0]  u_q, u_d;
  logic [ECntW-1:0]  e_q, e_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              ovalid_q, ovalid_d;
  out_word_t         oword_q, oword_d;

  logic              e_we;
  logic [EAddrW-1:0] e_waddr, e_raddr;
  logic [2*NodeW-1:0] e_rdata;
  logic              s_we;
  logic [SAddrW-1:0] s_waddr, s_raddr;
  logic [SDataW-1:0] s_wdata, s_rdata;

  logic [6:0] n_act;
  logic       take;

  assign n_act = (ncnt_q > 7'(MaxNodes)) ? 7'(MaxNodes) : ncnt_q;
  assign in_stall_o = (state_q != ST_IDLE) || (ovalid_q && in_word_i.opcode == OP_EVAL);
  assign take = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign out_word_o = oword_q;

  esnf_edge_mem #(.Depth(MaxEdges), .AddrW(EAddrW)) u_edges (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr),
    .wdata_i({in_word_i.from_node, in_word_i.to_node}),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  esnf_stack_mem #(.Depth(MaxNodes), .AddrW(SAddrW), .DataW(SDataW)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  always_comb begin
    logic [NodeW-1:0] w;
    logic [63:0] ub, wb;
    state_d = state_q; ecnt_d = ecnt_q; drop_d = drop_q;
    seen_d = seen_q; path_d = path_q; safe_d = safe_q;
    sp_d = sp_q; root_d = root_q; u_d = u_q; e_d = e_q; cnt_d = cnt_q;
    ovalid_d = ovalid_q && out_stall_i; oword_d = oword_q;
    e_we = 1'b0; e_waddr = EAddrW'(ecnt_q); e_raddr = EAddrW'(e_q);
    s_we = 1'b0; s_waddr = SAddrW'(sp_q); s_wdata = '0;
    s_raddr = SAddrW'(sp_q - SCntW'(1));
    w = e_rdata[NodeW-1:0];
    ub = 64'd1 << u_q;
    wb = 64'd1 << w;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (in_word_i.opcode == OP_ADD) begin
            if (7'(in_word_i.from_node) >= n_act || 7'(in_word_i.to_node) >= n_act ||
                ecnt_q >= ECntW'(MaxEdges)) begin
              drop_d = 1'b1;
            end else begin
              e_we = 1'b1;
              ecnt_d = ecnt_q + ECntW'(1);
            end
          end else begin
            seen_d = '0; path_d = '0; safe_d = '0;
            root_d = '0; cnt_d = '0;
            state_d = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (root_q >= n_act) begin
          state_d = ST_DONE;
        end else if (seen_q[root_q[5:0]]) begin
          root_d = root_q + 7'd1;
        end else begin
          s_we = 1'b1; s_waddr = '0;
          s_wdata = {root_q[NodeW-1:0], ECntW'(0)};
          seen_d[root_q[5:0]] = 1'b1; path_d[root_q[5:0]] = 1'b1;
          sp_d = SCntW'(1);
          state_d = ST_TOPRD;
        end
      end
      ST_TOPRD: begin
        if (sp_q == '0) begin
          root_d = root_q + 7'd1;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        u_d = s_rdata[SDataW-1:ECntW];
        e_d = s_rdata[ECntW-1:0];
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // issue read of entry e_q, checked next cycle
        if (e_q >= ecnt_q) begin
          safe_d = safe_q | ub; path_d = path_q & ~ub;
          cnt_d = cnt_q + CountW'(1);
          sp_d = sp_q - SCntW'(1);
          state_d = ST_TOPRD;
        end else begin
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (e_rdata[2*NodeW-1:NodeW] != u_q) begin
          e_d = e_q + ECntW'(1);
          state_d = ST_SCAN;
        end else begin
          // save the parent's cursor; a child level is only read back after
          // the child itself has pushed and written its own entry
          s_we = 1'b1; s_waddr = SAddrW'(sp_q - SCntW'(1));
          s_wdata = {u_q, ECntW'(e_q + ECntW'(1))};
          if (!(|(seen_q & wb))) begin
            if (sp_q >= SCntW'(MaxNodes)) begin
              root_d = root_q + 7'd1; state_d = ST_ROOT;
            end else begin
              seen_d = seen_q | wb; path_d = path_q | wb;
              u_d = w; e_d = '0; sp_d = sp_q + SCntW'(1);
              state_d = ST_SCAN;
            end
          end else if ((|(path_q & wb)) || !(|(safe_q & wb))) begin
            root_d = root_q + 7'd1; state_d = ST_ROOT;
          end else begin
            e_d = e_q + ECntW'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          oword_d.safe_mask = safe_q;
          oword_d.safe_count = cnt_q;
          oword_d.edges_dropped = drop_q;
          ecnt_d = '0; drop_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ncnt_q <= 7'd64; ecnt_q <= '0; drop_q <= 1'b0;
      seen_q <= '0; path_q <= '0; safe_q <= '0; sp_q <= '0;
      root_q <= '0; cnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ecnt_q <= ecnt_d; drop_q <= drop_d;
      seen_q <= seen_d; path_q <= path_d; safe_q <= safe_d; sp_q <= sp_d;
      root_q <= root_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d;
      if (cfg_we_i) ncnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d; e_q <= e_d; oword_q <= oword_d;
  end

endmodule

### rtl/core/esnf_checker.sv
// ----------------------------------------------------------------------------
// esnf_props
// Port-level checks for the eventual safe node finder.
// ----------------------------------------------------------------------------
module esnf_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input esnf_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input esnf_pkg::out_word_t out_word_o
);
  import esnf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

  a_eval_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.opcode == OP_EVAL |=> in_stall_o)
    else $error("input not stalled during walk");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.safe_count <= 7'd64)
    else $error("safe count out of range");

  a_count_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 7'($countones(out_word_o.safe_mask)) == out_word_o.safe_count)
    else $error("count and mask disagree");

endmodule

bind eventual_safe_node_finder esnf_props u_esnf_checker (.*);
